[rtl/file_magic_type_detector_macros.svh]
// Assertion macros used by the port-level checker of the file magic type detector.
`ifndef FILE_MAGIC_TYPE_DETECTOR_MACROS_SVH
`define FILE_MAGIC_TYPE_DETECTOR_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define FMTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FMTD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fmtd_pkg.sv]
// Types, signatures and helper functions of the file magic type detector.
package fmtd_pkg;

  localparam int TEXT_WINDOW_DEF = 512;
  localparam int HEADER_LEN = 8;
  localparam int HDR_IDX_W = $clog2(HEADER_LEN);
  localparam int HCW = $clog2(HEADER_LEN + 1);
  localparam int KIND_W = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNKNOWN = 4'd0,
    KIND_ELF     = 4'd1,
    KIND_MACHO   = 4'd2,
    KIND_PNG     = 4'd3,
    KIND_JPEG    = 4'd4,
    KIND_PDF     = 4'd5,
    KIND_GZIP    = 4'd6,
    KIND_ZIP     = 4'd7,
    KIND_PE      = 4'd8,
    KIND_TEXT    = 4'd9
  } kind_t;

  typedef logic [0:HEADER_LEN-1][7:0] header_t;
  typedef logic [HCW-1:0] hcnt_t;

  typedef struct packed {
    header_t header;
    hcnt_t   head_cnt;
    logic    text_ok;
  } status_t;

  localparam header_t SIG_ELF       = '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_MACHO_0   = '{8'hFE, 8'hED, 8'hFA, 8'hCE, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_MACHO_1   = '{8'hFE, 8'hED, 8'hFA, 8'hCF, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_MACHO_2   = '{8'hCE, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_MACHO_3   = '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_MACHO_4   = '{8'hCA, 8'hFE, 8'hBA, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_MACHO_5   = '{8'hBE, 8'hBA, 8'hFE, 8'hCA, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_PNG       = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam header_t SIG_JPEG      = '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_PDF       = '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_GZIP      = '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_ZIP       = '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_ZIP_EMPTY = '{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam header_t SIG_MZ        = '{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  localparam hcnt_t LEN_ELF   = 4'd4;
  localparam hcnt_t LEN_MACHO = 4'd4;
  localparam hcnt_t LEN_PNG   = 4'd8;
  localparam hcnt_t LEN_JPEG  = 4'd3;
  localparam hcnt_t LEN_PDF   = 4'd5;
  localparam hcnt_t LEN_GZIP  = 4'd2;
  localparam hcnt_t LEN_ZIP   = 4'd4;
  localparam hcnt_t LEN_MZ    = 4'd2;

  localparam logic [7:0] CHR_NUL = 8'h00;

  function automatic logic is_printable(input logic [7:0] c);
    return c inside {8'h09, 8'h0A, 8'h0D, [8'h20:8'h7E]};
  endfunction

  // The first len bytes must have arrived and must equal the signature.
  function automatic logic head_match(input header_t h, input hcnt_t cnt,
                                      input header_t sig, input hcnt_t len);
    logic ok;
    ok = (cnt >= len);
    for (int i = 0; i < HEADER_LEN; i++) begin
      if ((HCW'(i) < len) && (h[i] != sig[i])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[rtl/fmtd_byte_if.sv]
// Request channel that carries the bytes of a file.
interface fmtd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source(output valid, output data_byte, output has_byte, output is_last,
                 input ready);
  modport sink(input valid, input data_byte, input has_byte, input is_last,
               output ready);
endinterface

[rtl/fmtd_kind_if.sv]
// Request channel that carries one kind code per file.
interface fmtd_kind_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind_code;

  modport source(output valid, output kind_code, input ready);
  modport sink(input valid, input kind_code, output ready);
endinterface

[rtl/file_magic_type_detector.sv]
// Top level of the file magic type detector.
// The block takes one byte request per cycle and gives one kind code per file from the
// result register. Each request first lands in an input register; as it advances, it
// updates the header capture and counters and, on the last request, classifies the file
// into the result register. Only a pending last request waits on a full result register,
// so bytes keep flowing while a code waits to be taken.
module file_magic_type_detector #(
  parameter int TEXT_WINDOW = fmtd_pkg::TEXT_WINDOW_DEF
) (
  input logic        clk,
  input logic        rst,
  fmtd_byte_if.sink  bytes,
  fmtd_kind_if.source kind
);
  import fmtd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_has;
  logic       s1_last;
  logic       advance;
  logic       out_valid;
  kind_t      result_kind;
  kind_t      cls_kind;
  status_t    status;

  assign advance = s1_valid && (!s1_last || !out_valid || kind.ready);
  assign bytes.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.data_byte;
      s1_has <= bytes.has_byte;
      s1_last <= bytes.is_last;
    end
  end

  fmtd_stats #(
    .TEXT_WINDOW(TEXT_WINDOW)
  ) u_stats (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .data_byte(s1_byte),
    .has_byte(s1_has),
    .is_last(s1_last),
    .status(status)
  );

  fmtd_classify u_classify (
    .status(status),
    .kind(cls_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (kind.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      result_kind <= cls_kind;
    end
  end

  assign kind.valid = out_valid;
  assign kind.kind_code = result_kind;

endmodule

[rtl/fmtd_stats.sv]
// Per-file header capture, byte counters and text test.
module fmtd_stats #(
  parameter int TEXT_WINDOW = fmtd_pkg::TEXT_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              has_byte,
  input  logic              is_last,
  output fmtd_pkg::status_t status
);
  import fmtd_pkg::*;

  localparam int CW = $clog2(TEXT_WINDOW + 1);
  localparam int PW = CW + 4;

  header_t         header;
  header_t         header_next;
  logic [CW-1:0]   bytes_seen;
  logic [CW-1:0]   bytes_seen_next;
  logic [CW-1:0]   printable_count;
  logic [CW-1:0]   printable_count_next;
  logic            zero_byte_seen;
  logic            zero_byte_seen_next;
  logic            take;
  logic [PW-1:0]   lhs;
  logic [PW-1:0]   rhs;

  always_comb begin
    take = step && has_byte && (bytes_seen < CW'(TEXT_WINDOW));
    header_next = header;
    bytes_seen_next = bytes_seen;
    printable_count_next = printable_count;
    zero_byte_seen_next = zero_byte_seen;
    if (take) begin
      if (bytes_seen < CW'(HEADER_LEN)) begin
        header_next[bytes_seen[HDR_IDX_W-1:0]] = data_byte;
      end
      if (is_printable(data_byte)) begin
        printable_count_next = printable_count + CW'(1);
      end else if (data_byte == CHR_NUL) begin
        zero_byte_seen_next = 1'b1;
      end
      bytes_seen_next = bytes_seen + CW'(1);
    end
  end

  // Text when some byte was taken, none was NUL and at least nine tenths of the bytes in the window are printable.
  always_comb begin
    lhs = (PW'(printable_count_next) << 3) + (PW'(printable_count_next) << 1);
    rhs = (PW'(bytes_seen_next) << 3) + PW'(bytes_seen_next);
    status.header = header_next;
    status.head_cnt = (bytes_seen_next >= CW'(HEADER_LEN)) ? HCW'(HEADER_LEN)
                                                          : HCW'(bytes_seen_next);
    status.text_ok = (bytes_seen_next != '0) && !zero_byte_seen_next && (lhs >= rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      printable_count <= '0;
      zero_byte_seen <= 1'b0;
    end else if (step) begin
      if (is_last) begin
        bytes_seen <= '0;
        printable_count <= '0;
        zero_byte_seen <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        printable_count <= printable_count_next;
        zero_byte_seen <= zero_byte_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      header <= header_next;
    end
  end

endmodule

[rtl/fmtd_classify.sv]
// Signature match in fixed priority, with the text test as the fallback.
module fmtd_classify (
  input  fmtd_pkg::status_t status,
  output fmtd_pkg::kind_t   kind
);
  import fmtd_pkg::*;

  header_t h;
  hcnt_t   n;

  always_comb begin
    h = status.header;
    n = status.head_cnt;
    if (head_match(h, n, SIG_ELF, LEN_ELF)) begin
      kind = KIND_ELF;
    end else if (head_match(h, n, SIG_MACHO_0, LEN_MACHO) ||
                 head_match(h, n, SIG_MACHO_1, LEN_MACHO) ||
                 head_match(h, n, SIG_MACHO_2, LEN_MACHO) ||
                 head_match(h, n, SIG_MACHO_3, LEN_MACHO) ||
                 head_match(h, n, SIG_MACHO_4, LEN_MACHO) ||
                 head_match(h, n, SIG_MACHO_5, LEN_MACHO)) begin
      kind = KIND_MACHO;
    end else if (head_match(h, n, SIG_PNG, LEN_PNG)) begin
      kind = KIND_PNG;
    end else if (head_match(h, n, SIG_JPEG, LEN_JPEG)) begin
      kind = KIND_JPEG;
    end else if (head_match(h, n, SIG_PDF, LEN_PDF)) begin
      kind = KIND_PDF;
    end else if (head_match(h, n, SIG_GZIP, LEN_GZIP)) begin
      kind = KIND_GZIP;
    end else if (head_match(h, n, SIG_ZIP, LEN_ZIP) ||
                 head_match(h, n, SIG_ZIP_EMPTY, LEN_ZIP)) begin
      kind = KIND_ZIP;
    end else if (head_match(h, n, SIG_MZ, LEN_MZ)) begin
      kind = KIND_PE;
    end else if (status.text_ok) begin
      kind = KIND_TEXT;
    end else begin
      kind = KIND_UNKNOWN;
    end
  end

endmodule

[rtl/fmtd_checker.sv]
// Port-level checks of the file magic type detector and their binding.
`include "file_magic_type_detector_macros.svh"

module fmtd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] kind_code
);
  import fmtd_pkg::*;

  `FMTD_ASSERT_RST(a_reset_clears_result, rst |=> !out_valid, "result valid after reset")
  `FMTD_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(kind_code), "stalled result changed")
  `FMTD_ASSERT(a_kind_in_range, out_valid |-> kind_code <= KIND_TEXT, "kind code out of range")

endmodule

bind file_magic_type_detector fmtd_checker u_fmtd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(kind.valid),
  .out_ready(kind.ready),
  .kind_code(kind.kind_code)
);

[bench/file_magic_type_detector_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts the kind code of each file and compares it with the detector output.
module file_magic_type_detector_checker #(
  parameter int TEXT_WINDOW = fmtd_pkg::TEXT_WINDOW_DEF
) (
  input  logic clk,
  input  logic rst,
  fmtd_byte_if bytes,
  fmtd_kind_if kind,
  output int   fail_count,
  output int   pending
);
  import fmtd_pkg::*;

  header_t     head_q;
  int unsigned window_cnt;
  int unsigned print_cnt;
  bit          nul_seen;
  kind_t       kinds_due[$];
  kind_t       want;
  int          errors;

  function automatic bit head_is(input logic [63:0] sig, input int unsigned len);
    if (window_cnt < len) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (head_q[i] != sig[63-8*i -: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic kind_t file_kind();
    if (head_is(64'h7F454C46_00000000, 4)) return KIND_ELF;
    if (head_is(64'hFEEDFACE_00000000, 4) || head_is(64'hFEEDFACF_00000000, 4) ||
        head_is(64'hCEFAEDFE_00000000, 4) || head_is(64'hCFFAEDFE_00000000, 4) ||
        head_is(64'hCAFEBABE_00000000, 4) || head_is(64'hBEBAFECA_00000000, 4)) begin
      return KIND_MACHO;
    end
    if (head_is(64'h89504E47_0D0A1A0A, 8)) return KIND_PNG;
    if (head_is(64'hFFD8FF00_00000000, 3)) return KIND_JPEG;
    if (head_is(64'h25504446_2D000000, 5)) return KIND_PDF;
    if (head_is(64'h1F8B0000_00000000, 2)) return KIND_GZIP;
    if (head_is(64'h504B0304_00000000, 4) || head_is(64'h504B0506_00000000, 4)) begin
      return KIND_ZIP;
    end
    if (head_is(64'h4D5A0000_00000000, 2)) return KIND_PE;
    if (window_cnt != 0 && !nul_seen && print_cnt * 10 >= window_cnt * 9) return KIND_TEXT;
    return KIND_UNKNOWN;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    if (window_cnt < TEXT_WINDOW) begin
      if (window_cnt < HEADER_LEN) head_q[window_cnt] = b;
      if (b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b <= 8'h7E)) begin
        print_cnt++;
      end else if (b == 8'h00) begin
        nul_seen = 1'b1;
      end
      window_cnt++;
    end
  endtask

  task automatic clear_file();
    head_q = '0;
    window_cnt = 0;
    print_cnt = 0;
    nul_seen = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_file();
      kinds_due.delete();
      errors = 0;
    end else begin
      if (kind.valid && kind.ready) begin
        if (kinds_due.size() == 0) begin
          errors++;
          $display("%0t: kind code %0d arrived with no file pending", $time, kind.kind_code);
        end else begin
          want = kinds_due.pop_front();
          if (kind.kind_code !== want) begin
            errors++;
            $display("%0t: kind code mismatch: expected %0d (%s), actual %0d",
                     $time, want, want.name(), kind.kind_code);
          end
        end
      end
      if (bytes.valid && bytes.ready) begin
        if (bytes.has_byte) take_byte(bytes.data_byte);
        if (bytes.is_last) begin
          kinds_due.push_back(file_kind());
          clear_file();
        end
      end
    end
    fail_count <= errors;
    pending <= kinds_due.size();
  end

endmodule

[bench/file_magic_type_detector_tb.sv]
`timescale 1ns / 100ps
// Top of the detector testbench: clock, reset, file stimulus, result back-pressure and verdict.
module file_magic_type_detector_tb;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  logic [7:0] file_q[$];
  bit         sender_gaps;
  int         item_total;
  int         rand_base;
  int         recv_cycle;
  int         drain_wait;

  fmtd_byte_if bytes_ch();
  fmtd_kind_if kind_ch();

  file_magic_type_detector u_dut (
    .clk  (clk),
    .rst  (rst),
    .bytes(bytes_ch),
    .kind (kind_ch)
  );

  file_magic_type_detector_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes_ch),
    .kind      (kind_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [7:0] text_char();
    case ($urandom_range(19))
      0: return 8'h09;
      1: return 8'h0A;
      2: return 8'h0D;
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] binary_char(input bit nul_ok);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b <= 8'h7E) ||
               (!nul_ok && b == 8'h00));
    return b;
  endfunction

  function automatic void pick_magic(input int idx, output logic [63:0] sig, output int len);
    case (idx)
      0:  begin sig = 64'h7F454C46_00000000; len = 4; end
      1:  begin sig = 64'hFEEDFACE_00000000; len = 4; end
      2:  begin sig = 64'hFEEDFACF_00000000; len = 4; end
      3:  begin sig = 64'hCEFAEDFE_00000000; len = 4; end
      4:  begin sig = 64'hCFFAEDFE_00000000; len = 4; end
      5:  begin sig = 64'hCAFEBABE_00000000; len = 4; end
      6:  begin sig = 64'hBEBAFECA_00000000; len = 4; end
      7:  begin sig = 64'h89504E47_0D0A1A0A; len = 8; end
      8:  begin sig = 64'hFFD8FF00_00000000; len = 3; end
      9:  begin sig = 64'h25504446_2D000000; len = 5; end
      10: begin sig = 64'h1F8B0000_00000000; len = 2; end
      11: begin sig = 64'h504B0304_00000000; len = 4; end
      12: begin sig = 64'h504B0506_00000000; len = 4; end
      default: begin sig = 64'h4D5A0000_00000000; len = 2; end
    endcase
  endfunction

  task automatic push_request(input logic [7:0] b, input logic hb, input logic last);
    if (sender_gaps) begin
      while ($urandom_range(99) < 38) begin
        bytes_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.data_byte <= b;
    bytes_ch.has_byte <= hb;
    bytes_ch.is_last <= last;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    item_total++;
  endtask

  // A file may end on its last byte or on a separate request that carries no byte.
  task automatic send_file(input bit split_end);
    int n;
    n = file_q.size();
    if (n == 0) begin
      push_request(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 5) push_request(8'($urandom_range(255)), 1'b0, 1'b0);
        push_request(file_q[i], 1'b1, (i == n - 1) && !split_end);
      end
      if (split_end) push_request(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  task automatic random_file();
    logic [63:0] sig;
    int          len;
    int          n;
    int          pct;
    bit          nul_ok;
    int          pos;
    file_q.delete();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        pick_magic($urandom_range(13), sig, len);
        n = len + $urandom_range(10);
        if ($urandom_range(4) == 0) n = $urandom_range(1, len - 1);
        for (int i = 0; i < n; i++) begin
          if (i < len) file_q.push_back(sig[63-8*i -: 8]);
          else if ($urandom_range(1) == 0) file_q.push_back(text_char());
          else file_q.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(7) == 0) begin
          pos = $urandom_range(len - 1);
          if (pos < n) file_q[pos][$urandom_range(7)] ^= 1'b1;
        end
      end
      4, 5, 6: begin
        n = $urandom_range(1, 40);
        pct = $urandom_range(25);
        nul_ok = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99) < pct) file_q.push_back(binary_char(nul_ok));
          else file_q.push_back(text_char());
        end
      end
      7: begin
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) file_q.push_back(8'($urandom_range(255)));
      end
      8: begin
      end
      default: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(1) == 0) file_q.push_back(text_char());
          else file_q.push_back(8'($urandom_range(255)));
        end
      end
    endcase
    send_file($urandom_range(6) == 0);
  endtask

  // The window ends with the given number of binary bytes; the tail after it is arbitrary.
  task automatic long_file(input int nonprint);
    file_q.delete();
    for (int i = 0; i < fmtd_pkg::TEXT_WINDOW_DEF - nonprint; i++) file_q.push_back(text_char());
    for (int i = 0; i < nonprint; i++) file_q.push_back(binary_char(1'b0));
    repeat ($urandom_range(1, 8)) file_q.push_back(8'($urandom_range(255)));
    send_file(1'b0);
  endtask

  initial begin
    kind_ch.ready <= 1'b0;
    recv_cycle = 0;
    forever begin
      @(posedge clk);
      recv_cycle++;
      if (recv_cycle >= 150 && recv_cycle < 450) kind_ch.ready <= 1'b0;
      else if (recv_cycle >= 480 && recv_cycle < 800) kind_ch.ready <= 1'b1;
      else kind_ch.ready <= ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    bytes_ch.valid <= 1'b0;
    bytes_ch.data_byte <= 8'h00;
    bytes_ch.has_byte <= 1'b0;
    bytes_ch.is_last <= 1'b0;
    sender_gaps = 1'b1;
    item_total = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_request(8'hFF, 1'b0, 1'b1);
    push_request(8'h00, 1'b0, 1'b0);
    file_q = '{8'hFF};
    send_file(1'b0);
    file_q = '{8'h00};
    send_file(1'b0);
    file_q = '{8'h41};
    send_file(1'b0);
    file_q = '{8'h7E};
    send_file(1'b1);
    file_q = '{8'h7F, 8'h45, 8'h4C};
    send_file(1'b0);
    file_q = '{8'h7F, 8'h45, 8'h4C, 8'h46};
    send_file(1'b0);
    file_q = '{8'h1F, 8'h8B};
    send_file(1'b0);
    file_q = '{8'h4D, 8'h5A};
    send_file(1'b0);
    file_q = '{8'hFF, 8'hD8, 8'hFF};
    send_file(1'b0);

    rand_base = item_total;
    while (item_total - rand_base < 250) begin
      sender_gaps = !(item_total - rand_base >= 100 && item_total - rand_base < 200);
      random_file();
    end
    sender_gaps = 1'b1;

    long_file(51);
    long_file(52);
    bytes_ch.valid <= 1'b0;
    @(posedge clk);

    drain_wait = 0;
    while (pending != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/fmtd_pkg.sv
rtl/fmtd_byte_if.sv
rtl/fmtd_kind_if.sv
rtl/fmtd_stats.sv
rtl/fmtd_classify.sv
rtl/file_magic_type_detector.sv
rtl/fmtd_checker.sv
bench/file_magic_type_detector_checker.sv
bench/file_magic_type_detector_tb.sv
